// ===== rtl/pic_pkg.sv =====
// pic_pkg: types and constants shared by the property inline cache modules
// depends on nothing

package pic_pkg;

   localparam int SET_COUNT  = 256;
   localparam int SET_BITS   = $clog2(SET_COUNT);
   localparam int TAG_BITS   = 64;
   localparam int OFF_BITS   = 16;
   localparam int CNT_BITS   = 32;
   localparam int ENTRY_BITS = TAG_BITS + OFF_BITS;

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_FILL   = 1'b1
   } pic_func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } pic_state_type;

   typedef struct packed {
      pic_func_type func;
      logic [31:0]  class_id;
      logic [31:0]  property_key;
      logic [31:0]  name_hash;
      logic [15:0]  fill_offset;
   } pic_req_type;

   typedef struct packed {
      logic                hit;
      logic [OFF_BITS-1:0] found_offset;
      logic [CNT_BITS-1:0] lookup_count;
      logic [CNT_BITS-1:0] hit_count;
   } pic_rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } pic_cmd_type;

   function automatic logic [SET_BITS-1:0] set_of(input logic [31:0] cls,
                                                  input logic [31:0] hash);
      logic [31:0] mixed;
      mixed = hash ^ (cls + (cls << 4));
      return mixed[SET_BITS-1:0];
   endfunction

endpackage

// ===== rtl/pic_ctrl.sv =====
// pic_ctrl: handshake controller for the property inline cache
// depends on pic_pkg

module pic_ctrl
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pic_cmd_type cmd
);

   pic_state_type state_ff;
   pic_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.capture = req_valid && req_ready;
   end

endmodule

// ===== rtl/pic_datapath.sv =====
// pic_datapath: slot memories, valid bits, counters and result register
// depends on pic_pkg

module pic_datapath
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pic_cmd_type cmd,
   input  pic_req_type req_data,
   output pic_rsp_type rsp_data
);

   logic [ENTRY_BITS-1:0] prim_mem [SET_COUNT];
   logic [ENTRY_BITS-1:0] sec_mem  [SET_COUNT];

   pic_req_type           req_ff;
   logic [SET_BITS-1:0]   set_ff;
   logic [ENTRY_BITS-1:0] prim_rd_ff;
   logic [ENTRY_BITS-1:0] sec_rd_ff;
   logic [SET_COUNT-1:0]  prim_valid_ff;
   logic [SET_COUNT-1:0]  sec_valid_ff;
   logic [CNT_BITS-1:0]   lookups_ff;
   logic [CNT_BITS-1:0]   hits_ff;
   pic_rsp_type           rsp_ff;

   logic [SET_BITS-1:0]   set_in;
   logic [TAG_BITS-1:0]   tag;
   logic                  pv;
   logic                  sv;
   logic                  prim_match;
   logic                  sec_match;
   logic                  is_fill;
   logic                  prim_we;
   logic                  sec_we;
   logic                  hit;
   logic [OFF_BITS-1:0]   found;
   logic [CNT_BITS-1:0]   lookups_in;
   logic [CNT_BITS-1:0]   hits_in;

   assign set_in = set_of(req_data.class_id, req_data.name_hash);

   // request capture and registered memory read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff     <= req_data;
         set_ff     <= set_in;
         prim_rd_ff <= prim_mem[set_in];
         sec_rd_ff  <= sec_mem[set_in];
      end
   end

   assign tag        = {req_ff.class_id, req_ff.property_key};
   assign pv         = prim_valid_ff[set_ff];
   assign sv         = sec_valid_ff[set_ff];
   assign prim_match = pv && (prim_rd_ff[ENTRY_BITS-1:OFF_BITS] == tag);
   assign sec_match  = sv && (sec_rd_ff[ENTRY_BITS-1:OFF_BITS] == tag);
   assign is_fill    = (req_ff.func == FUNC_FILL);
   assign prim_we    = cmd.execute && is_fill && (!pv || sv);
   assign sec_we     = cmd.execute && is_fill && pv && !sv;

   always_comb begin
      hit   = 1'b0;
      found = '0;
      if (!is_fill) begin
         if (prim_match) begin
            hit   = 1'b1;
            found = prim_rd_ff[OFF_BITS-1:0];
         end else if (sec_match) begin
            hit   = 1'b1;
            found = sec_rd_ff[OFF_BITS-1:0];
         end
      end
      lookups_in = is_fill ? lookups_ff : lookups_ff + 1'b1;
      hits_in    = hit ? hits_ff + 1'b1 : hits_ff;
   end

   always_ff @(posedge clock) begin
      if (prim_we) begin
         prim_mem[set_ff] <= {tag, req_ff.fill_offset};
      end
      if (sec_we) begin
         sec_mem[set_ff] <= {tag, req_ff.fill_offset};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_valid_ff <= '0;
         sec_valid_ff  <= '0;
         lookups_ff    <= '0;
         hits_ff       <= '0;
      end else if (cmd.execute) begin
         lookups_ff <= lookups_in;
         hits_ff    <= hits_in;
         if (is_fill) begin
            if (!pv) begin
               prim_valid_ff[set_ff] <= 1'b1;
               sec_valid_ff[set_ff]  <= 1'b0;
            end else if (!sv) begin
               sec_valid_ff[set_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff.hit          <= hit;
         rsp_ff.found_offset <= found;
         rsp_ff.lookup_count <= lookups_in;
         rsp_ff.hit_count    <= hits_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/property_inline_cache.sv =====
// property_inline_cache: two-slot direct-mapped cache from (class, property) to offset
// depends on pic_pkg, pic_ctrl, pic_datapath
//
//   channel | ports                          | transfer
//   request | req_valid req_ready req_data   | lookup or fill item in
//   result  | rsp_valid rsp_ready rsp_data   | hit, offset and counters out
//
// result valid in RESP, after the execute state: the slot memories are read
// with a registered port at the transfer, then compared and updated in the next cycle
// back-to-back items alternate between EXEC and RESP while rsp_ready stays high
// a new request is taken in the cycle its predecessor's result transfers
// reset clears all valid bits and counters at once, no clearing pass

module property_inline_cache
   import pic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pic_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pic_rsp_type rsp_data
);

   pic_cmd_type cmd;

   pic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pic_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> $past(cmd.capture))
      else $error("execute without a preceding capture");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("no result after execute");

   a_no_take_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while result stalled");

   a_no_capture_in_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !cmd.capture)
      else $error("capture during execute");

endmodule

// ===== dv/property_inline_cache_test.sv =====
// property_inline_cache_test: checks the two-slot property inline cache against a predictor
// a directed table first, then collision-heavy random lookups and fills under idling phases
// depends on pic_pkg and property_inline_cache

`timescale 1ns / 100ps

module property_inline_cache_test;
   import pic_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 450;
   localparam int TAG_POOL_DEPTH = 40;

   typedef struct {
      pic_req_type req;
      bit          typed;
      pic_rsp_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   pic_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   pic_rsp_type rsp_data;

   logic                prim_valid [SET_COUNT];
   logic [TAG_BITS-1:0] prim_tag   [SET_COUNT];
   logic [OFF_BITS-1:0] prim_off   [SET_COUNT];
   logic                sec_valid  [SET_COUNT];
   logic [TAG_BITS-1:0] sec_tag    [SET_COUNT];
   logic [OFF_BITS-1:0] sec_off    [SET_COUNT];
   logic [CNT_BITS-1:0] lookups_seen;
   logic [CNT_BITS-1:0] hits_seen;

   pic_rsp_type pending_rsp [$];
   dir_row_type directed_rows [$];
   logic [31:0] pool_cls  [TAG_POOL_DEPTH];
   logic [31:0] pool_key  [TAG_POOL_DEPTH];
   logic [31:0] pool_hash [TAG_POOL_DEPTH];

   int          send_idle_pct = 0;
   int          rcv_idle_pct = 0;
   bit          hold_off_armed = 1'b0;
   bit          hold_off_taken = 1'b0;
   int          error_count = 0;
   int unsigned cycle_count = 0;

   property_inline_cache dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("property_inline_cache_test: done, errors");
         $finish;
      end
   end

   function automatic pic_rsp_type cache_predict(input pic_req_type r);
      logic [31:0]         mixed;
      int unsigned         idx;
      logic [TAG_BITS-1:0] tag;
      pic_rsp_type         res;
      mixed = r.name_hash ^ (r.class_id * 32'd17);
      idx = mixed % SET_COUNT;
      tag = {r.class_id, r.property_key};
      res = '0;
      if (r.func == FUNC_LOOKUP) begin
         lookups_seen = lookups_seen + 1'b1;
         if (prim_valid[idx] && prim_tag[idx] == tag) begin
            res.hit = 1'b1;
            res.found_offset = prim_off[idx];
         end else if (sec_valid[idx] && sec_tag[idx] == tag) begin
            res.hit = 1'b1;
            res.found_offset = sec_off[idx];
         end
         if (res.hit) hits_seen = hits_seen + 1'b1;
      end else if (!prim_valid[idx]) begin
         prim_tag[idx] = tag;
         prim_off[idx] = r.fill_offset;
         prim_valid[idx] = 1'b1;
         sec_valid[idx] = 1'b0;
      end else if (!sec_valid[idx]) begin
         sec_tag[idx] = tag;
         sec_off[idx] = r.fill_offset;
         sec_valid[idx] = 1'b1;
      end else begin
         prim_tag[idx] = tag;
         prim_off[idx] = r.fill_offset;
      end
      res.lookup_count = lookups_seen;
      res.hit_count = hits_seen;
      return res;
   endfunction

   function automatic void add_row(input pic_func_type f, input logic [31:0] cls,
                                   input logic [31:0] key, input logic [31:0] hash,
                                   input logic [15:0] off, input bit typed,
                                   input logic hit, input logic [15:0] found,
                                   input logic [31:0] lcount, input logic [31:0] hcount);
      dir_row_type row;
      row.req = '{func: f, class_id: cls, property_key: key, name_hash: hash, fill_offset: off};
      row.typed = typed;
      row.want = '{hit: hit, found_offset: found, lookup_count: lcount, hit_count: hcount};
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic pic_req_type random_item();
      pic_req_type r;
      int          pick;
      r.func = ($urandom_range(0, 99) < 40) ? FUNC_FILL : FUNC_LOOKUP;
      r.fill_offset = 16'($urandom());
      if ($urandom_range(0, 99) < 85) begin
         pick = $urandom_range(0, TAG_POOL_DEPTH - 1);
         r.class_id = pool_cls[pick];
         r.property_key = pool_key[pick];
         r.name_hash = pool_hash[pick];
      end else begin
         r.class_id = $urandom();
         r.property_key = $urandom();
         r.name_hash = $urandom();
      end
      return r;
   endfunction

   task automatic send_item(input pic_req_type r, input bit typed, input pic_rsp_type want);
      pic_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = cache_predict(r);
      pending_rsp.insert(pending_rsp.size(), typed ? want : predicted);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver side, with one long hold-off while the sender keeps going
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_armed && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pic_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer: %p", rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_data.hit);
               error_count++;
            end
            if (rsp_data.found_offset !== want.found_offset) begin
               $error("found_offset: expected %h, actual %h", want.found_offset,
                      rsp_data.found_offset);
               error_count++;
            end
            if (rsp_data.lookup_count !== want.lookup_count) begin
               $error("lookup_count: expected %0d, actual %0d", want.lookup_count,
                      rsp_data.lookup_count);
               error_count++;
            end
            if (rsp_data.hit_count !== want.hit_count) begin
               $error("hit_count: expected %0d, actual %0d", want.hit_count,
                      rsp_data.hit_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [31:0] mixed;
      logic [31:0] hash;
      for (int i = 0; i < SET_COUNT; i++) begin
         prim_valid[i] = 1'b0;
         prim_tag[i] = '0;
         prim_off[i] = '0;
         sec_valid[i] = 1'b0;
         sec_tag[i] = '0;
         sec_off[i] = '0;
      end
      lookups_seen = '0;
      hits_seen = '0;

      // tag pool crowded into a dozen sets so every fill case keeps coming up
      for (int i = 0; i < TAG_POOL_DEPTH; i++) begin
         pool_cls[i] = ($urandom_range(0, 9) == 0) ? 32'hffff_ffff : $urandom();
         pool_key[i] = ($urandom_range(0, 9) == 0) ? 32'h0000_0000 : $urandom();
         mixed = pool_cls[i] * 32'd17;
         hash = $urandom();
         hash[7:0] = 8'($urandom_range(0, 11)) ^ mixed[7:0];
         pool_hash[i] = hash;
      end

      add_row(FUNC_LOOKUP, 0, 0, 0, 16'h0000, 1, 0, 16'h0000, 1, 0);
      add_row(FUNC_FILL,   0, 0, 0, 16'hffff, 1, 0, 16'h0000, 1, 0);
      add_row(FUNC_LOOKUP, 0, 0, 0, 16'h0000, 1, 1, 16'hffff, 2, 1);
      add_row(FUNC_FILL,   0, 1, 0, 16'h0001, 1, 0, 16'h0000, 2, 1);
      add_row(FUNC_LOOKUP, 0, 1, 0, 16'h0000, 1, 1, 16'h0001, 3, 2);
      add_row(FUNC_FILL,   0, 2, 0, 16'h0002, 1, 0, 16'h0000, 3, 2);
      add_row(FUNC_LOOKUP, 0, 0, 0, 16'h0000, 1, 0, 16'h0000, 4, 2);
      add_row(FUNC_LOOKUP, 0, 2, 0, 16'h0000, 1, 1, 16'h0002, 5, 3);
      add_row(FUNC_LOOKUP, 0, 1, 0, 16'h0000, 1, 1, 16'h0001, 6, 4);
      // duplicate tag in both slots, primary wins
      add_row(FUNC_FILL,   0, 5, 1, 16'h1234, 1, 0, 16'h0000, 6, 4);
      add_row(FUNC_FILL,   0, 5, 1, 16'h5678, 1, 0, 16'h0000, 6, 4);
      add_row(FUNC_LOOKUP, 0, 5, 1, 16'h0000, 1, 1, 16'h1234, 7, 5);
      // empty secondary with a zero tag must not hit
      add_row(FUNC_FILL,   0, 7, 3, 16'h00aa, 1, 0, 16'h0000, 7, 5);
      add_row(FUNC_LOOKUP, 0, 0, 3, 16'h0000, 1, 0, 16'h0000, 8, 5);
      add_row(FUNC_LOOKUP, 0, 7, 3, 16'hffff, 1, 1, 16'h00aa, 9, 6);
      add_row(FUNC_FILL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              16'h0000, 0, 0, 0, 0, 0);
      add_row(FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              16'h0000, 0, 0, 0, 0, 0);
      add_row(FUNC_FILL,   1, 9, 32'h11, 16'h0bee, 0, 0, 0, 0, 0);
      add_row(FUNC_LOOKUP, 1, 9, 32'h11, 16'h0000, 0, 0, 0, 0, 0);
      add_row(FUNC_LOOKUP, 1, 9, 32'h12, 16'h0000, 0, 0, 0, 0, 0);
      add_row(FUNC_LOOKUP, 0, 0, 0, 16'h0000, 0, 0, 0, 0, 0);
      add_row(FUNC_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              16'h8000, 0, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 83 : 0;
         rcv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 33 : 0;
         if (phase == 2) hold_off_armed = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_item(random_item(), 1'b0, '0);
         drain_results();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("property_inline_cache_test: done, clean");
      end else begin
         $display("property_inline_cache_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pic_pkg.sv
rtl/pic_ctrl.sv
rtl/pic_datapath.sv
rtl/property_inline_cache.sv
dv/property_inline_cache_test.sv
